>>> rtl/bse_pkg.sv
// Shared constants for the battery state-of-charge estimator.
// Holds register indexes, reset values and the open-circuit-voltage table.
// No dependencies.
package bse_pkg;

    localparam int unsigned TABLE_POINTS = 11;
    localparam int unsigned LEVEL_W      = 33;
    localparam int unsigned PADDR_W      = 4;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 33'h1_0000_0000;
    localparam logic [LEVEL_W-1:0] HALF_LEVEL = 33'h0_8000_0000;
    localparam logic [21:0]        MS_PER_HOUR = 22'd3600000;

    localparam logic [1:0] REG_CAPACITY  = 2'd0;
    localparam logic [1:0] REG_REST_CUR  = 2'd1;
    localparam logic [1:0] REG_REST_TIME = 2'd2;
    localparam logic [1:0] REG_GAIN      = 2'd3;

    localparam logic [15:0] CAPACITY_RST  = 16'd7000;
    localparam logic [15:0] REST_CUR_RST  = 16'd140;
    localparam logic [31:0] REST_TIME_RST = 32'd300000;
    localparam logic [15:0] GAIN_RST      = 16'd655;

    localparam logic [15:0] OCV_MV [TABLE_POINTS] = '{
        16'd12890, 16'd12780, 16'd12650, 16'd12510, 16'd12410, 16'd12230,
        16'd12110, 16'd11960, 16'd11810, 16'd11700, 16'd11630
    };

    localparam logic [LEVEL_W-1:0] OCV_LEVEL [TABLE_POINTS] = '{
        33'd4294967296, 33'd3865470566, 33'd3435973837, 33'd3006477107,
        33'd2576980378, 33'd2147483648, 33'd1717986918, 33'd1288490189,
        33'd858993459,  33'd429496730,  33'd0
    };

endpackage

>>> rtl/bse_in_if.sv
// Input channel of the state-of-charge estimator: one battery sample.
// No dependencies.
interface bse_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] voltage_mv;
    logic signed [15:0] current_ma;
    logic        [15:0] dt_ms;

    modport source (output valid, voltage_mv, current_ma, dt_ms, input ready);
    modport sink   (input valid, voltage_mv, current_ma, dt_ms, output ready);
endinterface

>>> rtl/bse_out_if.sv
// Output channel of the state-of-charge estimator: one charge estimate.
// No dependencies.
interface bse_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] charge_fraction;
    logic [6:0]  charge_percent;
    logic        resting;

    modport source (output valid, charge_fraction, charge_percent, resting, input ready);
    modport sink   (input valid, charge_fraction, charge_percent, resting, output ready);
endinterface

>>> rtl/battery_soc_estimator.sv
// Battery state-of-charge estimator: coulomb counting with voltage correction.
// Depends on bse_pkg, bse_in_if and bse_out_if.
//
// Usage:
//   i_in carries one sample per transaction (voltage, signed current, elapsed
//   time). o_out returns exactly one estimate per sample: the charge fraction
//   in Q1.16, the truncated percent and a flag set when the voltage correction
//   was applied. Write registers via the APB port only while idle; not enforced.
//
// Datapath: bit-serial multipliers (two side by side for the coulomb step)
// and one restoring divider (one quotient bit per cycle) do the work. A
// sample without correction passes S_MUL, S_DIV, S_STEP and S_OUT. With
// correction inside the table range, S_STEP is followed by S_OCV, S_MUL,
// S_DIV, S_CPREP, S_MUL and S_APPLY before S_OUT; at a table end, by S_OCV,
// S_CPREP, S_MUL and S_APPLY. A new sample is taken only in the cycle after
// the previous one has reached the output register, so a sample is never
// accepted before the previous one is finished.
//
// Reset: synchronous, active low; registers return to their defaults, the
// level to half charge and the rest timer to zero. If the receiver stalls,
// the estimate is held and a finished next sample waits in its last state.
module battery_soc_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bse_in_if.sink                        i_in,
    bse_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bse_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned LW = bse_pkg::LEVEL_W;
    localparam int unsigned TP = bse_pkg::TABLE_POINTS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_STEP, S_OCV, S_CPREP, S_APPLY, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_COUL, PH_OCV, PH_CORR
    } t_phase;

    // Configuration registers
    logic [15:0] r_capacity;
    logic [15:0] r_rest_cur;
    logic [31:0] r_rest_time;
    logic [15:0] r_gain;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= bse_pkg::CAPACITY_RST;
            r_rest_cur  <= bse_pkg::REST_CUR_RST;
            r_rest_time <= bse_pkg::REST_TIME_RST;
            r_gain      <= bse_pkg::GAIN_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                bse_pkg::REG_CAPACITY:  r_capacity  <= pwdata[15:0];
                bse_pkg::REG_REST_CUR:  r_rest_cur  <= pwdata[15:0];
                bse_pkg::REG_REST_TIME: r_rest_time <= pwdata;
                bse_pkg::REG_GAIN:      r_gain      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bse_pkg::REG_CAPACITY:  prdata = {16'd0, r_capacity};
            bse_pkg::REG_REST_CUR:  prdata = {16'd0, r_rest_cur};
            bse_pkg::REG_REST_TIME: prdata = r_rest_time;
            bse_pkg::REG_GAIN:      prdata = {16'd0, r_gain};
            default:                prdata = 32'd0;
        endcase
    end

    // Datapath registers
    t_state         r_state;
    t_phase         r_phase;
    logic [5:0]     r_cnt;
    logic [15:0]    r_volt;
    logic           r_neg;
    logic [16:0]    r_mag_i;
    logic [15:0]    r_dt;
    logic [LW-1:0]  r_level;
    logic [31:0]    r_rest;
    logic [48:0]    r_ma;
    logic [15:0]    r_mb;
    logic [48:0]    r_acc;
    logic [37:0]    r_da;
    logic [15:0]    r_db;
    logic [37:0]    r_dacc;
    logic [63:0]    r_num;
    logic [37:0]    r_div;
    logic [38:0]    r_rem;
    logic [47:0]    r_quo;
    logic [LW-1:0]  r_seg_s2;
    logic [LW-1:0]  r_target;
    logic           r_up;
    logic           r_applied;
    logic           r_ovalid;
    logic [16:0]    r_frac;
    logic [6:0]     r_pct;
    logic           r_resting;

    function automatic logic [LW-1:0] move_level(input logic [LW-1:0] level,
                                                 input logic [47:0]   mag,
                                                 input logic          up);
        logic [LW-1:0] room;
        begin
            room = bse_pkg::FULL_LEVEL - level;
            if (up) begin
                if (mag >= {15'd0, room}) move_level = bse_pkg::FULL_LEVEL;
                else                      move_level = level + mag[LW-1:0];
            end else begin
                if (mag >= {15'd0, level}) move_level = '0;
                else                       move_level = level - mag[LW-1:0];
            end
        end
    endfunction

    // Serial multiply and divide steps
    logic [48:0] c_mul_sum;
    logic [37:0] c_dsum;
    logic [38:0] c_rem_sh;
    logic        c_ge;
    logic [47:0] c_quo_nxt;

    assign c_mul_sum = r_acc + (r_mb[0] ? r_ma : 49'd0);
    assign c_dsum    = r_dacc + (r_db[0] ? r_da : 38'd0);
    assign c_rem_sh  = {r_rem[37:0], r_num[63]};
    assign c_ge      = c_rem_sh >= {1'b0, r_div};
    assign c_quo_nxt = {r_quo[46:0], c_ge};

    // Input decode
    logic        c_in_neg;
    logic [16:0] c_in_mag;
    logic [15:0] c_cap_eff;

    assign c_in_neg  = i_in.current_ma[15];
    assign c_in_mag  = c_in_neg ? (17'h10000 - {1'b0, i_in.current_ma})
                                : {1'b0, i_in.current_ma};
    assign c_cap_eff = (r_capacity == 16'd0) ? 16'd1 : r_capacity;

    // Rest timer update
    logic [32:0] c_rest_sum;
    logic [31:0] c_rest_new;

    assign c_rest_sum = {1'b0, r_rest} + {17'd0, r_dt};
    always_comb begin
        if (r_mag_i < {1'b0, r_rest_cur}) begin
            c_rest_new = c_rest_sum[32] ? 32'hFFFF_FFFF : c_rest_sum[31:0];
        end else begin
            c_rest_new = 32'd0;
        end
    end

    // Table segment search
    logic          c_found;
    logic [15:0]   c_v1;
    logic [15:0]   c_v2;
    logic [LW-1:0] c_s1;
    logic [LW-1:0] c_s2;

    always_comb begin
        c_found = 1'b0;
        c_v1    = bse_pkg::OCV_MV[TP-1];
        c_v2    = bse_pkg::OCV_MV[TP-1];
        c_s1    = bse_pkg::OCV_LEVEL[TP-1];
        c_s2    = bse_pkg::OCV_LEVEL[TP-1];
        for (int i = 0; i < TP - 1; i++) begin
            if (!c_found && r_volt <= bse_pkg::OCV_MV[i]
                    && r_volt >= bse_pkg::OCV_MV[i+1]) begin
                c_found = 1'b1;
                c_v1    = bse_pkg::OCV_MV[i];
                c_v2    = bse_pkg::OCV_MV[i+1];
                c_s1    = bse_pkg::OCV_LEVEL[i];
                c_s2    = bse_pkg::OCV_LEVEL[i+1];
            end
        end
    end

    // Percent is level * 100 >> 32, built from shifts.
    logic [39:0] c_pct_full;
    assign c_pct_full = ({7'd0, r_level} << 6) + ({7'd0, r_level} << 5)
                      + ({7'd0, r_level} << 2);

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_ovalid;
    assign o_out.charge_fraction = r_frac;
    assign o_out.charge_percent  = r_pct;
    assign o_out.resting         = r_resting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_COUL;
            r_cnt     <= '0;
            r_level   <= bse_pkg::HALF_LEVEL;
            r_rest    <= '0;
            r_ovalid  <= 1'b0;
            r_applied <= 1'b0;
        end else begin
            // In S_OUT the output register is reloaded below instead.
            if (r_ovalid && o_out.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_volt  <= i_in.voltage_mv;
                        r_neg   <= c_in_neg;
                        r_mag_i <= c_in_mag;
                        r_dt    <= i_in.dt_ms;
                        r_ma    <= {32'd0, c_in_mag};
                        r_mb    <= i_in.dt_ms;
                        r_acc   <= '0;
                        r_da    <= {16'd0, bse_pkg::MS_PER_HOUR};
                        r_db    <= c_cap_eff;
                        r_dacc  <= '0;
                        r_cnt   <= '0;
                        r_phase <= PH_COUL;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc  <= c_mul_sum;
                    r_ma   <= {r_ma[47:0], 1'b0};
                    r_mb   <= {1'b0, r_mb[15:1]};
                    r_dacc <= c_dsum;
                    r_da   <= {r_da[36:0], 1'b0};
                    r_db   <= {1'b0, r_db[15:1]};
                    r_cnt  <= (r_cnt == 6'd15) ? 6'd0 : r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        r_rem <= '0;
                        r_quo <= '0;
                        case (r_phase)
                            PH_COUL: begin
                                r_num   <= {c_mul_sum[31:0], 32'd0};
                                r_div   <= c_dsum;
                                r_state <= S_DIV;
                            end
                            PH_OCV: begin
                                r_num   <= {15'd0, c_mul_sum};
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_state <= S_APPLY;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem <= c_ge ? (c_rem_sh - {1'b0, r_div}) : c_rem_sh;
                    r_quo <= c_quo_nxt;
                    r_num <= {r_num[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        if (r_phase == PH_COUL) begin
                            r_state <= S_STEP;
                        end else begin
                            r_target <= r_seg_s2 + c_quo_nxt[LW-1:0];
                            r_state  <= S_CPREP;
                        end
                    end
                end
                S_STEP: begin
                    r_level <= move_level(r_level, r_quo, !r_neg);
                    r_rest  <= c_rest_new;
                    if (c_rest_new >= r_rest_time) begin
                        r_applied <= 1'b1;
                        r_state   <= S_OCV;
                    end else begin
                        r_applied <= 1'b0;
                        r_state   <= S_OUT;
                    end
                end
                S_OCV: begin
                    if (r_volt >= bse_pkg::OCV_MV[0]) begin
                        r_target <= bse_pkg::OCV_LEVEL[0];
                        r_state  <= S_CPREP;
                    end else if (r_volt <= bse_pkg::OCV_MV[TP-1] || !c_found) begin
                        r_target <= bse_pkg::OCV_LEVEL[TP-1];
                        r_state  <= S_CPREP;
                    end else if (c_v1 <= c_v2 || c_s1 < c_s2) begin
                        r_target <= c_s2;
                        r_state  <= S_CPREP;
                    end else begin
                        // Interpolate: (s1 - s2) * (v - v2) / (v1 - v2).
                        r_seg_s2 <= c_s2;
                        r_ma     <= {16'd0, c_s1 - c_s2};
                        r_mb     <= r_volt - c_v2;
                        r_acc    <= '0;
                        r_div    <= {22'd0, c_v1 - c_v2};
                        r_cnt    <= '0;
                        r_phase  <= PH_OCV;
                        r_state  <= S_MUL;
                    end
                end
                S_CPREP: begin
                    r_up    <= (r_target >= r_level);
                    r_ma    <= (r_target >= r_level) ? {16'd0, r_target - r_level}
                                                     : {16'd0, r_level - r_target};
                    r_mb    <= r_gain;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_phase <= PH_CORR;
                    r_state <= S_MUL;
                end
                S_APPLY: begin
                    r_level <= move_level(r_level, {15'd0, r_acc[48:16]}, r_up);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid  <= 1'b1;
                        r_frac    <= r_level[32:16];
                        r_pct     <= c_pct_full[38:32];
                        r_resting <= r_applied;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> verif/bse_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL folder.
// This file holds the shared sample and estimate types used by the bench.
// No dependencies.
package bse_tb_pkg;

    typedef struct packed {
        logic [15:0]        voltage_mv;
        logic signed [15:0] current_ma;
        logic [15:0]        dt_ms;
    } t_sample;

    typedef struct packed {
        logic [16:0] charge_fraction;
        logic [6:0]  charge_percent;
        logic        resting;
    } t_estimate;

endpackage

>>> verif/tb_battery_soc_estimator.sv
`timescale 1ns / 1ps
// Testbench for battery_soc_estimator: directed and random samples, bursts and
// stalls, checked with a fixed-point state-of-charge predictor in the bench.
// Depends on bse_pkg, bse_tb_pkg, bse_in_if and bse_out_if.
module tb_battery_soc_estimator;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [bse_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bse_in_if  in_ch();
    bse_out_if out_ch();

    battery_soc_estimator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    logic [15:0] capacity_q, rest_cur_q, gain_q;
    logic [31:0] rest_time_q;
    logic [32:0] level_q;
    logic [31:0] rest_ms_q;

    bse_tb_pkg::t_sample   sample_queue[$];
    bse_tb_pkg::t_estimate estimate_queue[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;
    bit  drive_en = 1'b0;
    int  burst_left = 0, gap_left = 0;

    function automatic logic [32:0] nudge_level(logic [32:0] lvl, logic [63:0] mag, bit up);
        if (up) begin
            if (mag >= 64'(bse_pkg::FULL_LEVEL - lvl)) return bse_pkg::FULL_LEVEL;
            return lvl + 33'(mag);
        end
        if (mag >= 64'(lvl)) return '0;
        return lvl - 33'(mag);
    endfunction

    function automatic logic [32:0] ocv_target(logic [15:0] v);
        logic [63:0] s1, s2;
        if (v >= bse_pkg::OCV_MV[0]) return bse_pkg::OCV_LEVEL[0];
        if (v <= bse_pkg::OCV_MV[bse_pkg::TABLE_POINTS-1])
            return bse_pkg::OCV_LEVEL[bse_pkg::TABLE_POINTS-1];
        for (int k = 0; k + 1 < bse_pkg::TABLE_POINTS; k++) begin
            if (v <= bse_pkg::OCV_MV[k] && v >= bse_pkg::OCV_MV[k+1]) begin
                s1 = 64'(bse_pkg::OCV_LEVEL[k]);
                s2 = 64'(bse_pkg::OCV_LEVEL[k+1]);
                return 33'(s2 + ((s1 - s2) * 64'(v - bse_pkg::OCV_MV[k+1]))
                           / 64'(bse_pkg::OCV_MV[k] - bse_pkg::OCV_MV[k+1]));
            end
        end
        return bse_pkg::OCV_LEVEL[bse_pkg::TABLE_POINTS-1];
    endfunction

    function automatic bse_tb_pkg::t_estimate predict_estimate(bse_tb_pkg::t_sample s);
        bse_tb_pkg::t_estimate e;
        bit neg;
        logic [16:0] mag_i;
        logic [63:0] cap, step, diff, tsum;
        logic [32:0] target;
        bit up;
        neg = s.current_ma[15];
        mag_i = neg ? 17'(17'h10000 - 17'(s.current_ma[15:0])) : 17'(s.current_ma[15:0]);
        cap = (capacity_q == 0) ? 64'd1 : 64'(capacity_q);
        step = ((64'(mag_i) * 64'(s.dt_ms)) << 32) / (64'd3600000 * cap);
        level_q = nudge_level(level_q, step, !neg);
        if (mag_i < 17'(rest_cur_q)) begin
            tsum = 64'(rest_ms_q) + 64'(s.dt_ms);
            rest_ms_q = (tsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tsum[31:0];
        end else begin
            rest_ms_q = '0;
        end
        e.resting = 1'b0;
        if (rest_ms_q >= rest_time_q) begin
            target = ocv_target(s.voltage_mv);
            up = target >= level_q;
            diff = up ? 64'(target - level_q) : 64'(level_q - target);
            level_q = nudge_level(level_q, (diff * 64'(gain_q)) >> 16, up);
            e.resting = 1'b1;
        end
        e.charge_fraction = level_q[32:16];
        e.charge_percent = 7'((64'(level_q) * 64'd100) >> 32);
        return e;
    endfunction

    // Driver: bursts of transactions with random gaps.
    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            estimate_queue.push_back(predict_estimate(bse_tb_pkg::t_sample'(
                {in_ch.voltage_mv, in_ch.current_ma, in_ch.dt_ms})));
            void'(sample_queue.pop_front());
        end
        if (!drive_en || sample_queue.size() == 0 ||
            (in_ch.valid && in_ch.ready && sample_queue.size() == 0)) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            in_ch.valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            in_ch.valid <= 1'b0;
        end else begin
            in_ch.valid <= 1'b1;
            in_ch.voltage_mv <= sample_queue[0].voltage_mv;
            in_ch.current_ma <= sample_queue[0].current_ma;
            in_ch.dt_ms <= sample_queue[0].dt_ms;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 6);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
            end
        end
    end

    // Monitor and receiver stall pattern, including one long hold-off.
    always @(posedge i_clk) begin
        bse_tb_pkg::t_estimate got, want;
        if (out_ch.valid && out_ch.ready) begin
            got = '{out_ch.charge_fraction, out_ch.charge_percent, out_ch.resting};
            if (estimate_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected estimate %p", got);
            end else begin
                want = estimate_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 3) != 0) || (($urandom % 64) < 4);
        end
    end

    // Watchdog: cycles with no accepted transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !drive_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= bse_pkg::PADDR_W'({idx, 2'b00}); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            bse_pkg::REG_CAPACITY:  capacity_q = value[15:0];
            bse_pkg::REG_REST_CUR:  rest_cur_q = value[15:0];
            bse_pkg::REG_REST_TIME: rest_time_q = value;
            bse_pkg::REG_GAIN:      gain_q = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain_and_settle();
        drive_en = 1'b1;
        wait (sample_queue.size() == 0 && !in_ch.valid && estimate_queue.size() == 0);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic bse_tb_pkg::t_sample rand_sample(bit resting_bias);
        bse_tb_pkg::t_sample s;
        s.voltage_mv = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(11500, 13000));
        if (resting_bias && $urandom_range(0, 3) != 0)
            s.current_ma = 16'($urandom_range(0, 200)) - 16'sd100;
        else
            s.current_ma = 16'($urandom);
        case ($urandom_range(0, 3))
            0: s.dt_ms = 16'($urandom);
            1: s.dt_ms = 16'($urandom_range(0, 10));
            default: s.dt_ms = 16'($urandom_range(100, 5000));
        endcase
        return s;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.voltage_mv = '0; in_ch.current_ma = '0; in_ch.dt_ms = '0;
        out_ch.ready = 1'b0;
        capacity_q = bse_pkg::CAPACITY_RST; rest_cur_q = bse_pkg::REST_CUR_RST;
        rest_time_q = bse_pkg::REST_TIME_RST; gain_q = bse_pkg::GAIN_RST;
        level_q = bse_pkg::HALF_LEVEL; rest_ms_q = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: current and time extremes, table ends and breakpoints.
        sample_queue.push_back('{16'd12890, 16'sh7FFF, 16'hFFFF});
        sample_queue.push_back('{16'd0, -16'sd32768, 16'hFFFF});
        sample_queue.push_back('{16'hFFFF, -16'sd32768, 16'hFFFF});
        sample_queue.push_back('{16'd12000, 16'sd0, 16'd0});
        for (int k = 0; k < 8; k++)
            sample_queue.push_back('{16'd12000, 16'sd0, 16'hFFFF});
        drain_and_settle();

        // Fast correction: zero rest time, full gain, tiny capacity.
        write_reg(bse_pkg::REG_REST_TIME, 32'd0);
        write_reg(bse_pkg::REG_GAIN, 32'hFFFF);
        write_reg(bse_pkg::REG_CAPACITY, 32'd0);
        write_reg(bse_pkg::REG_REST_CUR, 32'd0);
        for (int k = 0; k < bse_pkg::TABLE_POINTS; k++)
            sample_queue.push_back('{bse_pkg::OCV_MV[k], 16'sd5, 16'd7});
        sample_queue.push_back('{16'd11629, 16'sh7FFF, 16'hFFFF});
        sample_queue.push_back('{16'd12891, -16'sd32768, 16'hFFFF});
        sample_queue.push_back('{16'd12300, 16'sd0, 16'd100});
        drain_and_settle();

        // Rest timer accumulation with maximum threshold and time.
        write_reg(bse_pkg::REG_REST_CUR, 32'hFFFF);
        write_reg(bse_pkg::REG_REST_TIME, 32'hFFFF_FFFF);
        write_reg(bse_pkg::REG_CAPACITY, 32'd1);
        write_reg(bse_pkg::REG_GAIN, 32'd0);
        for (int k = 0; k < 300; k++) sample_queue.push_back(rand_sample(1'b0));
        drain_and_settle();

        // Long receiver hold-off while the sender keeps offering.
        write_reg(bse_pkg::REG_CAPACITY, 32'hFFFF);
        write_reg(bse_pkg::REG_REST_TIME, 32'd2000);
        write_reg(bse_pkg::REG_REST_CUR, 32'd140);
        write_reg(bse_pkg::REG_GAIN, 32'd20000);
        for (int k = 0; k < 300; k++) sample_queue.push_back(rand_sample(1'b1));
        hold_req = 1'b1;
        drain_and_settle();

        // Back to the reset values and a mixed random run.
        write_reg(bse_pkg::REG_CAPACITY, 32'(bse_pkg::CAPACITY_RST));
        write_reg(bse_pkg::REG_REST_CUR, 32'(bse_pkg::REST_CUR_RST));
        write_reg(bse_pkg::REG_REST_TIME, bse_pkg::REST_TIME_RST);
        write_reg(bse_pkg::REG_GAIN, 32'(bse_pkg::GAIN_RST));
        for (int k = 0; k < 300; k++) sample_queue.push_back(rand_sample(1'b1));
        drain_and_settle();

        write_reg(bse_pkg::REG_CAPACITY, 32'($urandom_range(1, 3000)));
        write_reg(bse_pkg::REG_REST_TIME, 32'($urandom_range(0, 20000)));
        write_reg(bse_pkg::REG_GAIN, 32'($urandom));
        for (int k = 0; k < 330; k++) sample_queue.push_back(rand_sample(1'b1));
        drain_and_settle();

        if (mismatches == 0 && estimate_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
